FILE: rtl/core/iqrtm_pkg.sv
// Package for the trimmed-mean window block: field widths, defaults and codes.
// Used by every module under rtl/core; depends on nothing else.
package iqrtm_pkg;
	localparam int DefWindow   = 16;
	localparam int DefChannels = 9;
	localparam int DataW       = 16;
	localparam int ChanW       = 4;
	localparam int SumOutW     = 20;
	localparam int CntOutW     = 5;
	localparam int MeanW       = 32;

	localparam logic REQ_READING = 1'b0;
	localparam logic REQ_RESTART = 1'b1;
endpackage

FILE: rtl/core/iqrtm_store.sv
// Sample memory for the trimmed-mean window block: one array, one write port and
// one registered read port. Depends on iqrtm_pkg.
module iqrtm_store
	import iqrtm_pkg::*;
#(
	parameter int Depth = DefWindow * DefChannels,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [DataW-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [DataW-1:0] rd_data
);
	logic [DataW-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

FILE: rtl/core/iqrtm_divider.sv
// Restoring divider for the mean: one quotient bit a cycle, quotient masked to
// 32 bits. Depends on iqrtm_pkg.
module iqrtm_divider
	import iqrtm_pkg::*;
#(
	parameter int NumW = 38,
	parameter int DenW = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            done,
	output logic [MeanW-1:0] quot
);
	localparam int CW = $clog2(NumW + 1);
	logic [NumW-1:0] num_q;
	logic [NumW-1:0] quo_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;
	logic            fits;

	always_comb begin
		trial = {rem_q[DenW-1:0], num_q[NumW-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[NumW-2:0], fits};
		end
	end

	assign quot = quo_q[MeanW-1:0];
endmodule

FILE: rtl/core/iqr_trimmed_mean_window_top.sv
// Top level of the trimmed-mean window block: input and result channels, the
// sequencer that sorts and reduces each channel. Depends on iqrtm_pkg,
// iqrtm_store and iqrtm_divider.
//
// Usage: one beat on the input channel carries a restart request or one
// nine-channel reading. Restart empties the window; readings not warmed up,
// and readings after the window is full, are dropped. The beat that fills the
// window starts the reduction, and the block then sends one result beat per
// channel, channel 0 first, with last set on the final channel.
// Sequence: a restart or dropped beat is accepted, then passes through the
// done state before ready returns; a stored reading writes one channel a
// cycle, and the next beat is taken once all channels are written. The
// filling beat runs, per channel, an insertion sort over the shared memory
// (read the key, read v[j], then compare and move), a fence scan and a sum
// of the kept entries, then a bit-serial divide of 37 quotient bits for W of
// 16; most of its time goes to sort reads on the memory's single read port.
// The block holds in_ready low throughout. A result waits in its output
// register while the receiver stalls; the sequencer stops until it is taken.
// Reset clears the sample count and sequencer; the memory needs no clearing
// since only written entries are read.
module iqr_trimmed_mean_window_top
	import iqrtm_pkg::*;
#(
	parameter int WINDOW   = DefWindow,
	parameter int CHANNELS = DefChannels
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic               warmed_up,
	input  logic [DataW-1:0]   pm1p0_atm,
	input  logic [DataW-1:0]   pm2p5_atm,
	input  logic [DataW-1:0]   pm10_atm,
	input  logic [DataW-1:0]   count_0p3,
	input  logic [DataW-1:0]   count_0p5,
	input  logic [DataW-1:0]   count_1p0,
	input  logic [DataW-1:0]   count_2p5,
	input  logic [DataW-1:0]   count_5,
	input  logic [DataW-1:0]   count_10,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ChanW-1:0]   channel,
	output logic [SumOutW-1:0] trimmed_sum,
	output logic [CntOutW-1:0] kept_count,
	output logic [MeanW-1:0]   mean_fixed,
	output logic               last
);
	localparam int Depth = WINDOW * CHANNELS;
	localparam int AW    = $clog2(Depth);
	localparam int IW    = $clog2(WINDOW + 1);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SumW  = DataW + $clog2(WINDOW) + 1;
	localparam int NumW  = SumW + 16;
	localparam int Q1    = WINDOW / 4;
	localparam int Q3    = WINDOW - WINDOW / 4 - 1;

	// Sequencer codes.
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_WRITE = 5'd1;
	localparam logic [4:0] ST_SI    = 5'd2;   // read key v[i]
	localparam logic [4:0] ST_SIW   = 5'd3;
	localparam logic [4:0] ST_SJ    = 5'd4;   // read v[j]
	localparam logic [4:0] ST_SJW   = 5'd5;
	localparam logic [4:0] ST_SCMP  = 5'd6;   // compare, shift up or place key
	localparam logic [4:0] ST_Q1    = 5'd7;
	localparam logic [4:0] ST_Q1W   = 5'd8;
	localparam logic [4:0] ST_Q3    = 5'd9;
	localparam logic [4:0] ST_Q3W   = 5'd10;
	localparam logic [4:0] ST_FENCE = 5'd11;
	localparam logic [4:0] ST_LO    = 5'd12;
	localparam logic [4:0] ST_LOW   = 5'd13;
	localparam logic [4:0] ST_HI    = 5'd14;
	localparam logic [4:0] ST_HIW   = 5'd15;
	localparam logic [4:0] ST_SUM   = 5'd16;
	localparam logic [4:0] ST_SUMW  = 5'd17;
	localparam logic [4:0] ST_DIV   = 5'd18;
	localparam logic [4:0] ST_DIVW  = 5'd19;
	localparam logic [4:0] ST_OUT   = 5'd20;
	localparam logic [4:0] ST_DONE  = 5'd21;

	logic [4:0]       state_q;
	logic [IW-1:0]    count_q;
	logic [CHW-1:0]   ch_q;
	logic [CHW-1:0]   wch_q;
	logic [DataW-1:0] wdata_q [CHANNELS];
	logic [IW-1:0]    i_q;
	logic [IW:0]      j_q;      // signed-style: j may reach -1
	logic [DataW-1:0] key_q;
	logic [DataW-1:0] q1_q;
	logic [DataW-1:0] q3_q;
	logic signed [DataW+2:0] lowlim_q;
	logic signed [DataW+2:0] highlim_q;
	logic [IW-1:0]    lo_q;
	logic [IW-1:0]    hi_q;
	logic [IW-1:0]    k_q;
	logic [SumW-1:0]  sum_q;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [DataW-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [DataW-1:0] rd_data;
	logic [IW-1:0]    rd_idx;
	logic [IW-1:0]    wr_idx;
	logic [CHW-1:0]   wr_ch;
	logic             div_start;
	logic             div_done;
	logic [MeanW-1:0] div_quot;
	logic [IW-1:0]    cnt_full;
	logic             in_beat;
	logic             out_beat;
	logic [DataW:0]   iqr;
	logic [DataW+2:0] half3;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign cnt_full = hi_q - lo_q + 1'b1;

	iqrtm_store #(.Depth(Depth)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	iqrtm_divider #(.NumW(NumW), .DenW(IW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({sum_q, 16'h0000}),
		.den    (cnt_full),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Memory addressing: channel-major, WINDOW entries per channel.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = count_q;
		wr_ch   = wch_q;
		wr_data = wdata_q[wch_q];
		rd_idx  = i_q;
		if (state_q == ST_WRITE) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SCMP) begin
			wr_en = 1'b1;
			wr_ch = ch_q;
			if (!j_q[IW] && (rd_data > key_q)) begin
				wr_idx  = IW'(j_q + 1'b1);
				wr_data = rd_data;
			end else begin
				wr_idx  = IW'(j_q + 1'b1);
				wr_data = key_q;
			end
		end
		case (state_q)
			ST_SJ:   rd_idx = j_q[IW-1:0];
			ST_SJW:  rd_idx = j_q[IW-1:0];
			ST_Q1:   rd_idx = IW'(Q1);
			ST_Q3:   rd_idx = IW'(Q3);
			ST_LO:   rd_idx = lo_q;
			ST_HI:   rd_idx = hi_q;
			ST_SUM:  rd_idx = k_q;
			default: rd_idx = i_q;
		endcase
		wr_addr = AW'(wr_ch * WINDOW + wr_idx);
		rd_addr = AW'(ch_q * WINDOW + rd_idx);
	end

	assign iqr   = {1'b0, q3_q} - {1'b0, q1_q};
	assign half3 = ({2'b00, iqr} + {1'b0, iqr, 1'b0}) >> 1;
	assign div_start = (state_q == ST_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ch_q      <= '0;
			wch_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (req_type == REQ_RESTART) begin
							count_q <= '0;
							state_q <= ST_DONE;
						end else if (warmed_up && (count_q < IW'(WINDOW))) begin
							wch_q   <= '0;
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WRITE: begin
					if (wch_q == CHW'(CHANNELS - 1)) begin
						count_q <= count_q + 1'b1;
						if (count_q == IW'(WINDOW - 1)) begin
							ch_q    <= '0;
							i_q     <= IW'(1);
							state_q <= ST_SI;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						wch_q <= wch_q + 1'b1;
					end
				end
				ST_SI:  state_q <= ST_SIW;
				ST_SIW: begin
					key_q   <= rd_data;
					j_q     <= {1'b0, i_q} - 1'b1;
					state_q <= ST_SJ;
				end
				ST_SJ:  state_q <= ST_SJW;
				ST_SJW: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (!j_q[IW] && (rd_data > key_q)) begin
						j_q     <= j_q - 1'b1;
						state_q <= (j_q == '0) ? ST_SCMP : ST_SJ;
					end else if (i_q == IW'(WINDOW - 1)) begin
						state_q <= ST_Q1;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SI;
					end
				end
				ST_Q1:  state_q <= ST_Q1W;
				ST_Q1W: begin
					q1_q    <= rd_data;
					state_q <= ST_Q3;
				end
				ST_Q3:  state_q <= ST_Q3W;
				ST_Q3W: begin
					q3_q    <= rd_data;
					state_q <= ST_FENCE;
				end
				ST_FENCE: begin
					lowlim_q  <= $signed({3'b000, q1_q}) - $signed(half3);
					highlim_q <= $signed({3'b000, q3_q}) + $signed(half3);
					lo_q      <= '0;
					hi_q      <= IW'(WINDOW - 1);
					state_q   <= ST_LO;
				end
				ST_LO:  state_q <= ST_LOW;
				ST_LOW: begin
					if ((lo_q < IW'(Q1)) && ($signed({3'b000, rd_data}) < lowlim_q)) begin
						lo_q    <= lo_q + 1'b1;
						state_q <= ST_LO;
					end else begin
						state_q <= ST_HI;
					end
				end
				ST_HI:  state_q <= ST_HIW;
				ST_HIW: begin
					if ((hi_q > IW'(Q3)) && ($signed({3'b000, rd_data}) > highlim_q)) begin
						hi_q    <= hi_q - 1'b1;
						state_q <= ST_HI;
					end else begin
						k_q     <= lo_q;
						sum_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM:  state_q <= ST_SUMW;
				ST_SUMW: begin
					sum_q <= sum_q + SumW'(rd_data);
					if (k_q == hi_q) begin
						state_q <= ST_DIV;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_SUM;
					end
				end
				ST_DIV: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						channel     <= ChanW'(ch_q);
						trimmed_sum <= SumOutW'(sum_q);
						kept_count  <= CntOutW'(cnt_full);
						mean_fixed  <= div_quot;
						last        <= (ch_q == CHW'(CHANNELS - 1));
						out_valid   <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_beat) begin
						out_valid <= 1'b0;
						if (ch_q == CHW'(CHANNELS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							i_q     <= IW'(1);
							state_q <= ST_SI;
						end
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input payload capture on the accepted beat.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			wdata_q[0] <= pm1p0_atm;
			if (CHANNELS > 1) wdata_q[1 % CHANNELS] <= pm2p5_atm;
			if (CHANNELS > 2) wdata_q[2 % CHANNELS] <= pm10_atm;
			if (CHANNELS > 3) wdata_q[3 % CHANNELS] <= count_0p3;
			if (CHANNELS > 4) wdata_q[4 % CHANNELS] <= count_0p5;
			if (CHANNELS > 5) wdata_q[5 % CHANNELS] <= count_1p0;
			if (CHANNELS > 6) wdata_q[6 % CHANNELS] <= count_2p5;
			if (CHANNELS > 7) wdata_q[7 % CHANNELS] <= count_5;
			if (CHANNELS > 8) wdata_q[8 % CHANNELS] <= count_10;
		end
	end

`ifndef SYNTHESIS
	// The block never takes a new reading while a result is pending.
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");

	// A result only appears with the divider having just finished.
	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(div_done))
		else $error("result raised without division");

	// The kept count is never zero.
	a_kept_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kept_count != '0))
		else $error("kept count zero");
`endif
endmodule
